/* hdl/polygon_centroid_macros.svh */
// assertion macros for the polygon centroid block
// no dependencies; included by files that carry assertions
`ifndef POLYGON_CENTROID_MACROS_SVH
`define POLYGON_CENTROID_MACROS_SVH
`ifndef SYNTHESIS
`define PC_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("polygon centroid: same-cycle check failed");
`define PC_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("polygon centroid: next-cycle check failed");
`else
`define PC_IMPLY(lbl, clk, rst, ante, cons)
`define PC_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/pc_pkg.sv */
// shared widths, codes and structs of the polygon centroid block
// no dependencies
`timescale 1ns / 1ps

package pc_pkg;

   localparam int COORD_W  = 16;
   localparam int DIFF_W   = 17;
   localparam int SUM3_W   = 18;
   localparam int PROD_W   = 34;
   localparam int CROSS_W  = 35;
   localparam int WPROD_W  = 53;
   localparam int AREA_W   = 48;
   localparam int WSUM_W   = 64;
   localparam int DEN_W    = 50;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QLVL_W      = 3;

   localparam int QUO_W     = 17;
   localparam int DIV_CNT_W = 5;

   typedef enum logic [1:0] {
      KIND_POINT,
      KIND_SEGMENT,
      KIND_AREA
   } pc_kind_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_PREP,
      DV_ITER,
      DV_ROUND
   } pc_div_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START_X,
      BK_WAIT_X,
      BK_WAIT_Y,
      BK_SEND
   } pc_back_state_type;

   typedef struct packed {
      pc_kind_type               kind;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] prev_x;
      logic signed [COORD_W-1:0] prev_y;
   } pc_snap_type;

   typedef struct packed {
      pc_snap_type              snap;
      logic signed [AREA_W-1:0] area;
      logic signed [WSUM_W-1:0] wx;
      logic signed [WSUM_W-1:0] wy;
   } pc_entry_type;

   typedef struct packed {
      logic         push;
      pc_entry_type entry;
   } pc_qwr_type;

   typedef struct packed {
      logic                     start;
      logic signed [WSUM_W-1:0] num;
      logic signed [DEN_W-1:0]  den;
   } pc_div_cmd_type;

   typedef struct packed {
      logic                      done;
      logic signed [COORD_W-1:0] quo;
   } pc_div_res_type;

endpackage

/* hdl/pc_req_if.sv */
// vertex channel: valid/ready plus one vertex per beat
// depends on pc_pkg
`timescale 1ns / 1ps

interface pc_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [pc_pkg::COORD_W-1:0] vertex_x;
   logic signed [pc_pkg::COORD_W-1:0] vertex_y;
   logic                              is_last;

   modport source (output valid, output vertex_x, output vertex_y, output is_last,
                   input ready);
   modport sink (input valid, input vertex_x, input vertex_y, input is_last,
                 output ready);
endinterface

/* hdl/pc_rsp_if.sv */
// centroid channel: valid/ready plus one centroid per beat
// depends on pc_pkg
`timescale 1ns / 1ps

interface pc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pc_pkg::COORD_W-1:0] centroid_x;
   logic signed [pc_pkg::COORD_W-1:0] centroid_y;
   logic                              status;

   modport source (output valid, output centroid_x, output centroid_y, output status,
                   input ready);
   modport sink (input valid, input centroid_x, input centroid_y, input status,
                 output ready);
endinterface

/* hdl/polygon_centroid.sv */
// polygon centroid, triangle fan over a vertex stream.
// req_if carries one vertex per beat (signed Q12.4 x and y) and is_last on the
// final vertex of a polygon; rsp_if carries one centroid per polygon with
// status 1 when three or more vertices enclose zero area (centroid reads zero).
// Vertices are taken one per cycle while req_if.ready is high. The front runs a
// three-stage multiply and accumulate pipeline; a finished polygon then lands
// in a four-entry queue. The back pops it and, for three or more vertices with
// nonzero area, divides x and then y with one shared radix-2 divider; it takes
// one polygon at a time. req_if.ready drops when the queue plus the polygon
// ends still in the pipeline would exceed its depth.
// A result holds on rsp_if until taken; vertices keep flowing into the front
// meanwhile. Synchronous reset empties the pipeline and queue and starts a new
// polygon; req_if.ready is high as soon as reset is released.
`timescale 1ns / 1ps
`include "polygon_centroid_macros.svh"

module polygon_centroid #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic     clock,
   input  logic     reset,
   pc_req_if.sink   req_if,
   pc_rsp_if.source rsp_if
);

   pc_pkg::pc_qwr_type             qwr;
   pc_pkg::pc_entry_type           q_head;
   logic [pc_pkg::QLVL_W-1:0]      q_level;
   logic                           q_pop;

   pc_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_level (q_level),
      .qwr     (qwr)
   );

   pc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qwr   (qwr),
      .pop   (q_pop),
      .head  (q_head),
      .level (q_level)
   );

   pc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_level (q_level),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

   `PC_IMPLY(a_push_has_room, clock, reset, qwr.push, q_level != pc_pkg::QLVL_W'(pc_pkg::QUEUE_DEPTH))
   `PC_IMPLY(a_pop_not_empty, clock, reset, q_pop, q_level != '0)
   `PC_IMPLY(a_no_pop_while_sending, clock, reset, rsp_if.valid, !q_pop)
   `PC_NEXT(a_level_tracks_push, clock, reset, qwr.push && !q_pop, q_level == $past(q_level) + 1'b1)

endmodule

/* hdl/pc_queue.sv */
// small queue of finished polygon sums between front and back
// depends on pc_pkg
`timescale 1ns / 1ps

module pc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  pc_pkg::pc_qwr_type          qwr,
   input  logic                        pop,
   output pc_pkg::pc_entry_type        head,
   output logic [pc_pkg::QLVL_W-1:0]   level
);

   pc_pkg::pc_entry_type             mem_ff [pc_pkg::QUEUE_DEPTH];
   logic [pc_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [pc_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [pc_pkg::QLVL_W-1:0]        level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + pc_pkg::QPTR_W'(qwr.push);
      rd_ptr_in = rd_ptr_ff + pc_pkg::QPTR_W'(pop);
      level_in  = level_ff + pc_pkg::QLVL_W'(qwr.push) - pc_pkg::QLVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (qwr.push) begin
         mem_ff[wr_ptr_ff] <= qwr.entry;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign level = level_ff;

endmodule

/* hdl/pc_front.sv */
// front: takes vertices, tracks first/previous vertex, pipelines the fan sums
// depends on pc_pkg and pc_req_if; writes finished polygons to pc_queue
`timescale 1ns / 1ps

module pc_front #(
   parameter int MAX_VERTICES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   pc_req_if.sink                    req_if,
   input  logic [pc_pkg::QLVL_W-1:0] q_level,
   output pc_pkg::pc_qwr_type        qwr
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

   logic                              accept, take, contrib;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic signed [pc_pkg::COORD_W-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [pc_pkg::COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   pc_pkg::pc_kind_type               kind_in;
   logic [1:0]                        inflight;
   logic [pc_pkg::QLVL_W:0]           room_check;

   // stage 1: differences and coordinate sums
   logic                              s1_valid_ff, s1_last_ff, s1_contrib_ff;
   logic signed [pc_pkg::DIFF_W-1:0]  s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic signed [pc_pkg::DIFF_W-1:0]  s1_ax_in, s1_ay_in, s1_bx_in, s1_by_in;
   logic signed [pc_pkg::SUM3_W-1:0]  s1_sx_ff, s1_sy_ff, s1_sx_in, s1_sy_in;
   pc_pkg::pc_snap_type               s1_snap_ff, s1_snap_in;

   // stage 2: doubled triangle area
   logic                              s2_valid_ff, s2_last_ff;
   logic signed [pc_pkg::PROD_W-1:0]  prod_a, prod_b;
   logic signed [pc_pkg::CROSS_W-1:0] s2_d_ff, s2_d_in;
   logic signed [pc_pkg::SUM3_W-1:0]  s2_sx_ff, s2_sy_ff;
   pc_pkg::pc_snap_type               s2_snap_ff;

   // stage 3: area-weighted coordinates
   logic                              s3_valid_ff, s3_last_ff;
   logic signed [pc_pkg::CROSS_W-1:0] s3_d_ff;
   logic signed [pc_pkg::WPROD_W-1:0] s3_mx_ff, s3_my_ff, s3_mx_in, s3_my_in;
   pc_pkg::pc_snap_type               s3_snap_ff;

   // running sums
   logic signed [pc_pkg::AREA_W-1:0]  acc_area_ff, acc_area_in, area_cur;
   logic signed [pc_pkg::WSUM_W-1:0]  acc_x_ff, acc_x_in, wx_cur;
   logic signed [pc_pkg::WSUM_W-1:0]  acc_y_ff, acc_y_in, wy_cur;

   // room is reserved for every polygon end still in the pipeline
   always_comb begin
      inflight   = 2'(s1_valid_ff & s1_last_ff) + 2'(s2_valid_ff & s2_last_ff)
                 + 2'(s3_valid_ff & s3_last_ff);
      room_check = {1'b0, q_level} + {{(pc_pkg::QLVL_W - 1){1'b0}}, inflight};
   end

   assign req_if.ready = room_check < (pc_pkg::QLVL_W + 1)'(pc_pkg::QUEUE_DEPTH);
   assign accept       = req_if.valid & req_if.ready;

   always_comb begin
      take       = count_ff < CNT_MAX;
      contrib    = take && (count_ff >= CNT_W'(2));
      first_x_in = (take && count_ff == '0) ? req_if.vertex_x : first_x_ff;
      first_y_in = (take && count_ff == '0) ? req_if.vertex_y : first_y_ff;
      prev_x_in  = take ? req_if.vertex_x : prev_x_ff;
      prev_y_in  = take ? req_if.vertex_y : prev_y_ff;
      count_in   = take ? count_ff + CNT_W'(1) : count_ff;

      priority if (count_in == CNT_W'(1)) begin
         kind_in = pc_pkg::KIND_POINT;
      end else if (count_in == CNT_W'(2)) begin
         kind_in = pc_pkg::KIND_SEGMENT;
      end else begin
         kind_in = pc_pkg::KIND_AREA;
      end

      s1_ax_in = {prev_x_ff[15], prev_x_ff} - {first_x_ff[15], first_x_ff};
      s1_ay_in = {prev_y_ff[15], prev_y_ff} - {first_y_ff[15], first_y_ff};
      s1_bx_in = {req_if.vertex_x[15], req_if.vertex_x} - {first_x_ff[15], first_x_ff};
      s1_by_in = {req_if.vertex_y[15], req_if.vertex_y} - {first_y_ff[15], first_y_ff};
      s1_sx_in = {{2{first_x_ff[15]}}, first_x_ff} + {{2{prev_x_ff[15]}}, prev_x_ff}
               + {{2{req_if.vertex_x[15]}}, req_if.vertex_x};
      s1_sy_in = {{2{first_y_ff[15]}}, first_y_ff} + {{2{prev_y_ff[15]}}, prev_y_ff}
               + {{2{req_if.vertex_y[15]}}, req_if.vertex_y};

      s1_snap_in.kind    = kind_in;
      s1_snap_in.first_x = first_x_in;
      s1_snap_in.first_y = first_y_in;
      s1_snap_in.prev_x  = prev_x_in;
      s1_snap_in.prev_y  = prev_y_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= req_if.is_last ? '0 : count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
      end else if (accept) begin
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
      end
   end

   always_comb begin
      prod_a  = s1_ax_ff * s1_by_ff;
      prod_b  = s1_ay_ff * s1_bx_ff;
      s2_d_in = s1_contrib_ff ? ({prod_a[pc_pkg::PROD_W-1], prod_a}
                                 - {prod_b[pc_pkg::PROD_W-1], prod_b}) : '0;
      s3_mx_in = s2_d_ff * s2_sx_ff;
      s3_my_in = s2_d_ff * s2_sy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff    <= req_if.is_last;
      s1_contrib_ff <= contrib;
      s1_ax_ff      <= s1_ax_in;
      s1_ay_ff      <= s1_ay_in;
      s1_bx_ff      <= s1_bx_in;
      s1_by_ff      <= s1_by_in;
      s1_sx_ff      <= s1_sx_in;
      s1_sy_ff      <= s1_sy_in;
      s1_snap_ff    <= s1_snap_in;

      s2_last_ff    <= s1_last_ff;
      s2_d_ff       <= s2_d_in;
      s2_sx_ff      <= s1_sx_ff;
      s2_sy_ff      <= s1_sy_ff;
      s2_snap_ff    <= s1_snap_ff;

      s3_last_ff    <= s2_last_ff;
      s3_d_ff       <= s2_d_ff;
      s3_mx_ff      <= s3_mx_in;
      s3_my_ff      <= s3_my_in;
      s3_snap_ff    <= s2_snap_ff;
   end

   always_comb begin
      area_cur = acc_area_ff
               + {{(pc_pkg::AREA_W - pc_pkg::CROSS_W){s3_d_ff[pc_pkg::CROSS_W-1]}}, s3_d_ff};
      wx_cur   = acc_x_ff
               + {{(pc_pkg::WSUM_W - pc_pkg::WPROD_W){s3_mx_ff[pc_pkg::WPROD_W-1]}}, s3_mx_ff};
      wy_cur   = acc_y_ff
               + {{(pc_pkg::WSUM_W - pc_pkg::WPROD_W){s3_my_ff[pc_pkg::WPROD_W-1]}}, s3_my_ff};

      acc_area_in = acc_area_ff;
      acc_x_in    = acc_x_ff;
      acc_y_in    = acc_y_ff;
      if (s3_valid_ff) begin
         acc_area_in = s3_last_ff ? '0 : area_cur;
         acc_x_in    = s3_last_ff ? '0 : wx_cur;
         acc_y_in    = s3_last_ff ? '0 : wy_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_area_ff <= '0;
         acc_x_ff    <= '0;
         acc_y_ff    <= '0;
      end else begin
         acc_area_ff <= acc_area_in;
         acc_x_ff    <= acc_x_in;
         acc_y_ff    <= acc_y_in;
      end
   end

   always_comb begin
      qwr.push        = s3_valid_ff & s3_last_ff;
      qwr.entry.snap  = s3_snap_ff;
      qwr.entry.area  = area_cur;
      qwr.entry.wx    = wx_cur;
      qwr.entry.wy    = wy_cur;
   end

endmodule

/* hdl/pc_div.sv */
// rounding divider: one quotient bit per cycle, saturates to a signed 16-bit result
// depends on pc_pkg; used by pc_back
`timescale 1ns / 1ps

module pc_div (
   input  logic                   clock,
   input  logic                   reset,
   input  pc_pkg::pc_div_cmd_type cmd,
   output pc_pkg::pc_div_res_type res
);

   pc_pkg::pc_div_state_type         state_ff, state_in;
   logic                             neg_ff, neg_in;
   logic [pc_pkg::WSUM_W-1:0]        un_ff, un_in;
   logic [pc_pkg::DEN_W-1:0]         ud_ff, ud_in;
   logic [pc_pkg::WSUM_W-1:0]        rem_ff, rem_in;
   logic [pc_pkg::WSUM_W+1:0]        dsh_ff, dsh_in;
   logic [pc_pkg::QUO_W-1:0]         q_ff, q_in;
   logic [pc_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                             ovf_ff, ovf_in;
   logic                             ge, round_up;
   logic [pc_pkg::QUO_W:0]           q_round, limit, mag_sat;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pc_pkg::DV_IDLE:  if (cmd.start) state_in = pc_pkg::DV_PREP;
         pc_pkg::DV_PREP:  state_in = pc_pkg::DV_ITER;
         pc_pkg::DV_ITER: begin
            if (cnt_ff == pc_pkg::DIV_CNT_W'(pc_pkg::QUO_W - 1)) state_in = pc_pkg::DV_ROUND;
         end
         pc_pkg::DV_ROUND: state_in = cmd.start ? pc_pkg::DV_PREP : pc_pkg::DV_IDLE;
         default:          state_in = pc_pkg::DV_IDLE;
      endcase
   end

   always_comb begin
      ge = {2'b00, rem_ff} >= dsh_ff;

      neg_in = neg_ff;
      un_in  = un_ff;
      ud_in  = ud_ff;
      if (cmd.start) begin
         neg_in = cmd.num[pc_pkg::WSUM_W-1] ^ cmd.den[pc_pkg::DEN_W-1];
         un_in  = cmd.num[pc_pkg::WSUM_W-1] ? (pc_pkg::WSUM_W'(0) - cmd.num) : cmd.num;
         ud_in  = cmd.den[pc_pkg::DEN_W-1] ? (pc_pkg::DEN_W'(0) - cmd.den) : cmd.den;
      end

      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      unique case (state_ff)
         pc_pkg::DV_PREP: begin
            // quotient no longer fits 17 bits: result saturates anyway
            ovf_in = {3'b000, un_ff} >= {ud_ff, {pc_pkg::QUO_W{1'b0}}};
            rem_in = un_ff;
            dsh_in = {ud_ff, {(pc_pkg::QUO_W - 1){1'b0}}};
            q_in   = '0;
            cnt_in = '0;
         end
         pc_pkg::DV_ITER: begin
            if (ge) rem_in = rem_ff - dsh_ff[pc_pkg::WSUM_W-1:0];
            q_in   = {q_ff[pc_pkg::QUO_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + pc_pkg::DIV_CNT_W'(1);
         end
         default: ;
      endcase
   end

   // round half away from zero, then clamp to the signed 16-bit range
   always_comb begin
      round_up = {rem_ff[pc_pkg::DEN_W:0], 1'b0} >= {2'b00, ud_ff};
      q_round  = {1'b0, q_ff} + (pc_pkg::QUO_W + 1)'(round_up);
      limit    = neg_ff ? (pc_pkg::QUO_W + 1)'(32768) : (pc_pkg::QUO_W + 1)'(32767);
      mag_sat  = (ovf_ff || q_round > limit) ? limit : q_round;
      res.done = state_ff == pc_pkg::DV_ROUND;
      res.quo  = neg_ff ? pc_pkg::COORD_W'((pc_pkg::QUO_W + 1)'(0) - mag_sat)
                        : pc_pkg::COORD_W'(mag_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pc_pkg::DV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      un_ff  <= un_in;
      ud_ff  <= ud_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
   end

endmodule

/* hdl/pc_back.sv */
// back: pops finished polygons, finishes the centroid and drives the result channel
// depends on pc_pkg, pc_rsp_if and pc_div
`timescale 1ns / 1ps

module pc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [pc_pkg::QLVL_W-1:0] q_level,
   input  pc_pkg::pc_entry_type      q_head,
   output logic                      q_pop,
   pc_rsp_if.source                  rsp_if
);

   pc_pkg::pc_back_state_type         state_ff, state_in;
   pc_pkg::pc_div_cmd_type            div_cmd;
   pc_pkg::pc_div_res_type            div_res;
   logic signed [pc_pkg::WSUM_W-1:0]  wx_ff, wx_in, wy_ff, wy_in;
   logic signed [pc_pkg::DEN_W-1:0]   den_ff, den_in, den_calc;
   logic signed [pc_pkg::COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [pc_pkg::COORD_W-1:0] head_cx, head_cy;
   logic                              status_ff, status_in, head_status;
   logic                              area_zero, needs_div;

   // midpoint, rounded half away from zero
   function automatic logic signed [15:0] half_round(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
      logic [16:0] s;
      logic [16:0] mag;
      logic [16:0] h;
      s   = {a[15], a} + {b[15], b};
      mag = s[16] ? (17'd0 - s) : s;
      h   = (mag + 17'd1) >> 1;
      half_round = s[16] ? 16'(17'd0 - h) : 16'(h);
   endfunction

   always_comb begin
      area_zero = q_head.area == '0;
      needs_div = (q_head.snap.kind == pc_pkg::KIND_AREA) && !area_zero;
      den_calc  = {{2{q_head.area[pc_pkg::AREA_W-1]}}, q_head.area}
                + {q_head.area[pc_pkg::AREA_W-1], q_head.area, 1'b0};

      head_cx     = '0;
      head_cy     = '0;
      head_status = 1'b0;
      unique case (q_head.snap.kind)
         pc_pkg::KIND_POINT: begin
            head_cx = q_head.snap.first_x;
            head_cy = q_head.snap.first_y;
         end
         pc_pkg::KIND_SEGMENT: begin
            head_cx = half_round(q_head.snap.first_x, q_head.snap.prev_x);
            head_cy = half_round(q_head.snap.first_y, q_head.snap.prev_y);
         end
         pc_pkg::KIND_AREA: head_status = area_zero;
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pc_pkg::BK_IDLE: begin
            if (q_level != '0) state_in = needs_div ? pc_pkg::BK_START_X : pc_pkg::BK_SEND;
         end
         pc_pkg::BK_START_X: state_in = pc_pkg::BK_WAIT_X;
         pc_pkg::BK_WAIT_X:  if (div_res.done) state_in = pc_pkg::BK_WAIT_Y;
         pc_pkg::BK_WAIT_Y:  if (div_res.done) state_in = pc_pkg::BK_SEND;
         pc_pkg::BK_SEND:    if (rsp_if.ready) state_in = pc_pkg::BK_IDLE;
         default:            state_in = pc_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = (state_ff == pc_pkg::BK_IDLE) && (q_level != '0);
      div_cmd.start = (state_ff == pc_pkg::BK_START_X)
                    || ((state_ff == pc_pkg::BK_WAIT_X) && div_res.done);
      div_cmd.num   = (state_ff == pc_pkg::BK_WAIT_X) ? wy_ff : wx_ff;
      div_cmd.den   = den_ff;
      rsp_if.valid  = state_ff == pc_pkg::BK_SEND;
   end

   always_comb begin
      wx_in     = wx_ff;
      wy_in     = wy_ff;
      den_in    = den_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      status_in = status_ff;
      if (q_pop) begin
         wx_in     = q_head.wx;
         wy_in     = q_head.wy;
         den_in    = den_calc;
         cx_in     = head_cx;
         cy_in     = head_cy;
         status_in = head_status;
      end
      if (state_ff == pc_pkg::BK_WAIT_X && div_res.done) cx_in = div_res.quo;
      if (state_ff == pc_pkg::BK_WAIT_Y && div_res.done) cy_in = div_res.quo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pc_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      wx_ff     <= wx_in;
      wy_ff     <= wy_in;
      den_ff    <= den_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      status_ff <= status_in;
   end

   pc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign rsp_if.centroid_x = cx_ff;
   assign rsp_if.centroid_y = cy_ff;
   assign rsp_if.status     = status_ff;

endmodule

/* sim/testbench.sv */
// testbench for polygon_centroid: directed rows and random polygons
// each beat is checked against a typed row or fan-triangle predictor in this file
// depends on pc_pkg, pc_req_if, pc_rsp_if and the polygon_centroid rtl
`timescale 1ns / 1ps

module testbench;

   localparam int VERTEX_LIMIT = 4096;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1128;
   localparam int HOLD_CYCLES  = 1500;
   localparam int HOLD_AFTER   = 20;
   localparam int DRAIN_CYCLES = 80;
   localparam int RESET_CYCLES = 11;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_DEGENERATE = 1'b1;

   typedef logic signed [pc_pkg::COORD_W-1:0] coord_type;

   typedef struct {
      coord_type cx;
      coord_type cy;
      logic      status;
   } centroid_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
      bit        typed;
      coord_type cx;
      coord_type cy;
      logic      status;
   } vertex_row_type;

   typedef enum int {
      SHAPE_WIDE,
      SHAPE_TIGHT,
      SHAPE_LINE,
      SHAPE_SLIVER,
      SHAPE_POINT
   } shape_type;

   logic clock;
   logic reset = 1'b1;

   pc_req_if req_bus ();
   pc_rsp_if rsp_bus ();

   polygon_centroid #(
      .MAX_VERTICES(VERTEX_LIMIT)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor state for the polygon being streamed
   coord_type fan_first_x, fan_first_y, fan_prev_x, fan_prev_y;
   int        fan_count;
   longint    area2_sum, moment_x_sum, moment_y_sum;

   centroid_type centroid_queue[$];
   centroid_type no_override = '{0, 0, STATUS_OK};
   int           error_count = 0;
   int           random_items = 0;
   bit           sender_steady = 1'b0;
   bit           receiver_steady = 1'b0;
   int unsigned  cycle_count = 0;

   // typed rows give the expected centroid directly; the rest use the predictor
   vertex_row_type directed_rows [0:21] = '{
      '{ 32767, -32768, 1, 1,  32767, -32768, STATUS_OK},
      '{-32768,  32767, 1, 1, -32768,  32767, STATUS_OK},
      '{     0,      0, 0, 0,      0,      0, STATUS_OK},
      '{     3,     -3, 1, 1,      2,     -2, STATUS_OK},
      '{ 32767,  32767, 0, 0,      0,      0, STATUS_OK},
      '{ 32767,  32767, 1, 1,  32767,  32767, STATUS_OK},
      '{-32768, -32768, 0, 0,      0,      0, STATUS_OK},
      '{-32768, -32768, 1, 1, -32768, -32768, STATUS_OK},
      '{     0,      0, 0, 0,      0,      0, STATUS_OK},
      '{    16,     16, 0, 0,      0,      0, STATUS_OK},
      '{    32,     32, 1, 1,      0,      0, STATUS_DEGENERATE},
      '{     0,      0, 0, 0,      0,      0, STATUS_OK},
      '{    48,      0, 0, 0,      0,      0, STATUS_OK},
      '{     0,     48, 1, 1,     16,     16, STATUS_OK},
      // area nearly cancels: quotient runs far past the positive limit
      '{     0,      0, 0, 0,      0,      0, STATUS_OK},
      '{ 32767,      0, 0, 0,      0,      0, STATUS_OK},
      '{ 32767,      1, 0, 0,      0,      0, STATUS_OK},
      '{    -1,     -1, 1, 0,      0,      0, STATUS_OK},
      // mirrored: past the negative limit
      '{     0,      0, 0, 0,      0,      0, STATUS_OK},
      '{-32767,      0, 0, 0,      0,      0, STATUS_OK},
      '{-32767,      1, 0, 0,      0,      0, STATUS_OK},
      '{     1,     -1, 1, 0,      0,      0, STATUS_OK}
   };

   function automatic void fan_clear();
      fan_first_x  = '0;
      fan_first_y  = '0;
      fan_prev_x   = '0;
      fan_prev_y   = '0;
      fan_count    = 0;
      area2_sum    = 0;
      moment_x_sum = 0;
      moment_y_sum = 0;
   endfunction

   // halve with ties away from zero
   function automatic coord_type half_to_nearest(input longint s);
      return coord_type'((s >= 0 ? s + 1 : s - 1) / 2);
   endfunction

   // num / den to nearest, ties away from zero, clamped to the coordinate range
   function automatic coord_type rounded_quotient(input longint num, input longint den);
      longint unsigned mag_num, mag_den, q, r;
      bit negative;
      negative = (num < 0) != (den < 0);
      mag_num  = num < 0 ? -num : num;
      mag_den  = den < 0 ? -den : den;
      q = mag_num / mag_den;
      r = mag_num % mag_den;
      if (2 * r >= mag_den) q++;
      if (negative) return (q >= 64'd32768) ? coord_type'(-32768) : coord_type'(-longint'(q));
      return (q > 64'd32767) ? coord_type'(32767) : coord_type'(q);
   endfunction

   // one vertex into the fan; returns 1 with the centroid when the polygon closes
   function automatic bit fan_vertex(input coord_type x, input coord_type y, input logic last,
                                     output centroid_type res);
      longint ax, ay, bx, by, twice_area;
      res = '{0, 0, STATUS_OK};
      if (fan_count < VERTEX_LIMIT) begin
         if (fan_count == 0) begin
            fan_first_x = x;
            fan_first_y = y;
         end else if (fan_count >= 2) begin
            ax = longint'(fan_prev_x) - fan_first_x;
            ay = longint'(fan_prev_y) - fan_first_y;
            bx = longint'(x) - fan_first_x;
            by = longint'(y) - fan_first_y;
            twice_area    = ax * by - ay * bx;
            area2_sum    += twice_area;
            moment_x_sum += twice_area * (longint'(fan_first_x) + fan_prev_x + x);
            moment_y_sum += twice_area * (longint'(fan_first_y) + fan_prev_y + y);
         end
         fan_prev_x = x;
         fan_prev_y = y;
         fan_count++;
      end
      if (!last) return 1'b0;
      if (fan_count == 1) begin
         res.cx = fan_first_x;
         res.cy = fan_first_y;
      end else if (fan_count == 2) begin
         res.cx = half_to_nearest(longint'(fan_first_x) + fan_prev_x);
         res.cy = half_to_nearest(longint'(fan_first_y) + fan_prev_y);
      end else if (area2_sum == 0) begin
         res.status = STATUS_DEGENERATE;
      end else begin
         res.cx = rounded_quotient(moment_x_sum, 3 * area2_sum);
         res.cy = rounded_quotient(moment_y_sum, 3 * area2_sum);
      end
      fan_clear();
      return 1'b1;
   endfunction

   task automatic send_vertex(input coord_type x, input coord_type y, input logic last,
                              input bit typed, input centroid_type typed_res);
      centroid_type predicted;
      int gap;
      if ($urandom_range(0, 39) == 0) sender_steady = !sender_steady;
      gap = sender_steady ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.vertex_x <= x;
      req_bus.vertex_y <= y;
      req_bus.is_last  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (fan_vertex(x, y, last, predicted))
         centroid_queue.push_back(typed ? typed_res : predicted);
   endtask

   task automatic send_random_polygon();
      int size, pick, k;
      int base_x, base_y, step_x, step_y;
      shape_type shape;
      coord_type x, y;
      pick = $urandom_range(0, 99);
      if (pick < 10)      size = 1;
      else if (pick < 20) size = 2;
      else if (pick < 30) size = 3;
      else if (pick < 80) size = $urandom_range(4, 12);
      else if (pick < 96) size = $urandom_range(13, 60);
      else                size = $urandom_range(61, 300);
      shape  = shape_type'($urandom_range(0, 4));
      base_x = int'($urandom_range(0, 32000)) - 16000;
      base_y = int'($urandom_range(0, 32000)) - 16000;
      step_x = int'($urandom_range(0, 2000)) - 1000;
      step_y = int'($urandom_range(0, 2000)) - 1000;
      for (int n = 0; n < size; n++) begin
         k = int'($urandom_range(0, 30)) - 15;
         case (shape)
            SHAPE_WIDE: begin
               x = coord_type'($urandom);
               y = coord_type'($urandom);
            end
            SHAPE_TIGHT: begin
               x = coord_type'(int'($urandom_range(0, 128)) - 64);
               y = coord_type'(int'($urandom_range(0, 128)) - 64);
            end
            // all on one line: zero area
            SHAPE_LINE: begin
               x = coord_type'(base_x + k * step_x);
               y = coord_type'(base_y + k * step_y);
            end
            // one-lsb jitter off a line: tiny area, large quotients
            SHAPE_SLIVER: begin
               x = coord_type'(base_x + k * step_x);
               y = coord_type'(base_y + k * step_y + int'($urandom_range(0, 2)) - 1);
            end
            default: begin
               x = coord_type'(base_x);
               y = coord_type'(base_y);
            end
         endcase
         send_vertex(x, y, n == size - 1, 1'b0, no_override);
         random_items++;
      end
   endtask

   // centroid side: random stalls, one long hold-off to back the block up
   initial begin
      int gap;
      int taken;
      bit held;
      centroid_type want;
      taken = 0;
      held  = 1'b0;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) receiver_steady = !receiver_steady;
         gap = receiver_steady ? 0 : $urandom_range(0, 12);
         if (taken == HOLD_AFTER && !held) begin
            gap  = HOLD_CYCLES;
            held = 1'b1;
         end
         repeat (gap) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         taken++;
         if (centroid_queue.size() == 0) begin
            $error("centroid beat with no polygon pending");
            error_count++;
         end else begin
            want = centroid_queue.pop_front();
            if (rsp_bus.centroid_x !== want.cx) begin
               $error("centroid_x: expected %0d, got %0d", want.cx, rsp_bus.centroid_x);
               error_count++;
            end
            if (rsp_bus.centroid_y !== want.cy) begin
               $error("centroid_y: expected %0d, got %0d", want.cy, rsp_bus.centroid_y);
               error_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      centroid_type typed_res;
      req_bus.valid    <= 1'b0;
      req_bus.vertex_x <= '0;
      req_bus.vertex_y <= '0;
      req_bus.is_last  <= 1'b0;
      fan_clear();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_res = '{directed_rows[i].cx, directed_rows[i].cy, directed_rows[i].status};
         send_vertex(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last,
                     directed_rows[i].typed, typed_res);
      end

      while (random_items < RANDOM_ITEMS) send_random_polygon();
      req_bus.valid <= 1'b0;

      while (centroid_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
